@@ src/vcps_pkg.sv @@
// vcps_pkg: widths, codes, item types and the saturation helper of the
// Verlet particle solver. No dependencies; every other file uses it.
package vcps_pkg;

	localparam int FRAC_BITS  = 12;
	localparam int POS_BITS   = 26;
	localparam int GRAV_W     = 26;
	localparam int ARENA_W    = 25;
	localparam int RAD_W      = 18;
	localparam int DT_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 26;

	localparam int DIFF_W     = POS_BITS + 1;   // center differences, limits
	localparam int SQ_W       = 2 * DIFF_W;     // dx*dx + dy*dy
	localparam int REM_W      = SQ_W + 2;       // square root remainder
	localparam int ROOT_W     = DIFF_W;         // distance
	localparam int DEN_W      = ROOT_W + 1;     // divisor (2*dist or dist)
	localparam int PROD_W     = 2 * DIFF_W;     // dx * factor
	localparam int DREM_W     = PROD_W + 2;     // divider remainder
	localparam int QUO_W      = DIFF_W;         // push magnitude
	localparam int DT2_W      = 2 * DT_W;
	localparam int ACC_SHIFT  = DT2_W;
	localparam int ACC_W      = GRAV_W + DT2_W + 1;
	localparam int SAT_W      = POS_BITS + 4;
	localparam int Q_PTR_W    = 2;
	localparam int Q_DEPTH    = 1 << Q_PTR_W;

	typedef logic signed [POS_BITS-1:0] pos_t;
	typedef logic signed [DIFF_W-1:0]   diff_t;
	typedef logic signed [GRAV_W-1:0]   grav_t;
	typedef logic [ARENA_W-1:0]         arena_t;
	typedef logic [RAD_W-1:0]           rad_t;
	typedef logic [DT_W-1:0]            dt_t;
	typedef logic [SQ_W-1:0]            sq_t;
	typedef logic [DEN_W-1:0]           den_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic signed [SAT_W-1:0]    wide_t;

	localparam pos_t   POS_MAX    = {1'b0, {(POS_BITS-1){1'b1}}};
	localparam pos_t   POS_MIN    = {1'b1, {(POS_BITS-1){1'b0}}};
	localparam grav_t  GRAV_Y_RST = GRAV_W'(500 << FRAC_BITS);
	localparam arena_t ARENA_RST  = ARENA_W'(1024 << FRAC_BITS);
	localparam acc_t   ACC_HALF   = ACC_W'(64'd1 << (ACC_SHIFT - 1));

	typedef enum logic [1:0] {
		KIND_INTEGRATE = 2'd0,
		KIND_COLLIDE   = 2'd1,
		KIND_ARENA     = 2'd2,
		KIND_NONE      = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRAVITY_X = 3'd0,
		CFG_GRAVITY_Y = 3'd1,
		CFG_CENTER_X  = 3'd2,
		CFG_CENTER_Y  = 3'd3,
		CFG_ARENA_R   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		grav_t  gravity_x;
		grav_t  gravity_y;
		arena_t center_x;
		arena_t center_y;
		arena_t arena_r;
	} cfg_t;

	// classified item as it leaves the front
	typedef struct packed {
		kind_t kind;
		pos_t  px;
		pos_t  py;
		pos_t  qx;
		pos_t  qy;
		pos_t  ox;
		pos_t  oy;
		dt_t   dt;
		diff_t dx;
		diff_t dy;
		diff_t lim;   // reach for a pair, arena_r - radius for the arena
	} item_t;

	// item plus the integrate result, carried down the back pipeline
	typedef struct packed {
		item_t it;
		pos_t  ix;
		pos_t  iy;
	} bctx_t;

	typedef struct packed {
		bctx_t c;
		logic  hit;
		den_t  den;
		logic  negx;
		logic  negy;
	} dmeta_t;

	function automatic pos_t sat_pos(input wide_t v);
		pos_t r;
		if (v > SAT_W'(POS_MAX))
			r = POS_MAX;
		else if (v < SAT_W'(POS_MIN))
			r = POS_MIN;
		else
			r = v[POS_BITS-1:0];
		return r;
	endfunction

endpackage

@@ src/vcps_if.sv @@
// vcps_req_if / vcps_rsp_if: valid/ready channels of the particle solver.
// Depends on vcps_pkg.
interface vcps_req_if;
	import vcps_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	pos_t       pos_x;
	pos_t       pos_y;
	pos_t       prev_x;
	pos_t       prev_y;
	rad_t       radius;
	pos_t       other_x;
	pos_t       other_y;
	rad_t       other_radius;
	dt_t        step_time;

	modport source (output valid, kind, pos_x, pos_y, prev_x, prev_y, radius,
		other_x, other_y, other_radius, step_time, input ready);
	modport sink (input valid, kind, pos_x, pos_y, prev_x, prev_y, radius,
		other_x, other_y, other_radius, step_time, output ready);
endinterface

interface vcps_rsp_if;
	import vcps_pkg::*;
	logic valid;
	logic ready;
	pos_t new_x;
	pos_t new_y;
	pos_t new_prev_x;
	pos_t new_prev_y;
	pos_t other_new_x;
	pos_t other_new_y;
	logic moved;

	modport source (output valid, new_x, new_y, new_prev_x, new_prev_y,
		other_new_x, other_new_y, moved, input ready);
	modport sink (input valid, new_x, new_y, new_prev_x, new_prev_y,
		other_new_x, other_new_y, moved, output ready);
endinterface

@@ src/vcps_front.sv @@
// vcps_front: accepts request items, decodes the kind and forms the center
// differences and the reach/limit term. Depends on vcps_pkg, vcps_if.
module vcps_front (
	input  logic            clk,
	input  logic            arst_n,
	input  vcps_pkg::cfg_t  cfg,
	vcps_req_if.sink        req,
	output vcps_pkg::item_t item,
	output logic            item_valid,
	input  logic            item_ready
);
	import vcps_pkg::*;

	item_t cls;
	item_t item_q;
	logic  v_q;
	logic  take;

	always_comb begin
		cls.kind = kind_t'(req.kind);
		cls.px   = req.pos_x;
		cls.py   = req.pos_y;
		cls.qx   = req.prev_x;
		cls.qy   = req.prev_y;
		cls.ox   = req.other_x;
		cls.oy   = req.other_y;
		cls.dt   = req.step_time;
		cls.dx   = '0;
		cls.dy   = '0;
		cls.lim  = '0;
		unique case (cls.kind)
			KIND_COLLIDE: begin
				cls.dx  = DIFF_W'(req.pos_x) - DIFF_W'(req.other_x);
				cls.dy  = DIFF_W'(req.pos_y) - DIFF_W'(req.other_y);
				cls.lim = DIFF_W'(req.radius) + DIFF_W'(req.other_radius);
			end
			KIND_ARENA: begin
				cls.dx  = DIFF_W'(req.pos_x) - $signed(DIFF_W'(cfg.center_x));
				cls.dy  = DIFF_W'(req.pos_y) - $signed(DIFF_W'(cfg.center_y));
				cls.lim = $signed(DIFF_W'(cfg.arena_r) - DIFF_W'(req.radius));
			end
			KIND_INTEGRATE, KIND_NONE: ;
		endcase
	end

	assign req.ready  = !v_q || item_ready;
	assign take       = req.valid && req.ready;
	assign item       = item_q;
	assign item_valid = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (take)
			v_q <= 1'b1;
		else if (item_ready)
			v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			item_q <= cls;
	end

endmodule

@@ src/vcps_queue.sv @@
// vcps_queue: small FIFO of classified items between front and back.
// Depends on vcps_pkg.
module vcps_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  vcps_pkg::item_t push_item,
	input  logic            push_valid,
	output logic            push_ready,
	output vcps_pkg::item_t pop_item,
	output logic            pop_valid,
	input  logic            pop_ready
);
	import vcps_pkg::*;

	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_PTR_W:0]   cnt_q;
	logic               push;
	logic               pop;

	assign push_ready = cnt_q != (Q_PTR_W+1)'(Q_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

endmodule

@@ src/vcps_back.sv @@
// vcps_back: execution pipeline - squares, integrate, pipelined square root,
// push products, pipelined rounding divider, output register.
// Depends on vcps_pkg, vcps_if.
module vcps_back (
	input  logic            clk,
	input  logic            arst_n,
	input  vcps_pkg::cfg_t  cfg,
	input  vcps_pkg::item_t item,
	input  logic            item_valid,
	output logic            item_ready,
	vcps_rsp_if.source      rsp
);
	import vcps_pkg::*;

	logic adv;   // whole pipeline moves when the output slot frees up

	assign adv        = !rsp.valid || rsp.ready;
	assign item_ready = adv;

	// s1: squares and dt^2
	logic               v_s1;
	item_t              it_s1;
	sq_t                sqx_s1;
	sq_t                sqy_s1;
	logic [DT2_W-1:0]   dt2_s1;

	// s2: sum of squares, g*dt^2
	logic  v_s2;
	item_t it_s2;
	sq_t   sum_s2;
	acc_t  gx_s2;
	acc_t  gy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1  <= item;
			sqx_s1 <= sq_t'(PROD_W'(item.dx) * PROD_W'(item.dx));
			sqy_s1 <= sq_t'(PROD_W'(item.dy) * PROD_W'(item.dy));
			dt2_s1 <= DT2_W'(item.dt) * DT2_W'(item.dt);
			it_s2  <= it_s1;
			sum_s2 <= sqx_s1 + sqy_s1;
			gx_s2  <= ACC_W'(cfg.gravity_x) * $signed(ACC_W'(dt2_s1));
			gy_s2  <= ACC_W'(cfg.gravity_y) * $signed(ACC_W'(dt2_s1));
		end
	end

	// integrate: 2*pos - prev + round(g*dt^2)
	acc_t  rx;
	acc_t  ry;
	wide_t tx;
	wide_t ty;

	always_comb begin
		rx = gx_s2 + ACC_HALF;
		ry = gy_s2 + ACC_HALF;
		tx = (SAT_W'(it_s2.px) <<< 1) - SAT_W'(it_s2.qx)
			+ SAT_W'($signed(rx[ACC_W-1:ACC_SHIFT]));
		ty = (SAT_W'(it_s2.py) <<< 1) - SAT_W'(it_s2.qy)
			+ SAT_W'($signed(ry[ACC_W-1:ACC_SHIFT]));
	end

	// square root, one result bit per stage; index 0 is s3
	logic              sq_v_s   [ROOT_W+1];
	bctx_t             sq_ctx_s [ROOT_W+1];
	logic [REM_W-1:0]  sq_rem_s [ROOT_W+1];
	logic [ROOT_W-1:0] sq_root_s[ROOT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_v_s[0] <= 1'b0;
		else if (adv)
			sq_v_s[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_ctx_s[0]  <= '{it: it_s2, ix: sat_pos(tx), iy: sat_pos(ty)};
			sq_rem_s[0]  <= REM_W'(sum_s2);
			sq_root_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		localparam int K = ROOT_W - 1 - j;
		logic [REM_W-1:0] trial;

		// (root + 2^K)^2 - root^2
		assign trial = (REM_W'(sq_root_s[j]) << (K + 1)) + (REM_W'(1) << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_s[j+1] <= 1'b0;
			else if (adv)
				sq_v_s[j+1] <= sq_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_ctx_s[j+1] <= sq_ctx_s[j];
				if (sq_rem_s[j] >= trial) begin
					sq_rem_s[j+1]  <= sq_rem_s[j] - trial;
					sq_root_s[j+1] <= sq_root_s[j] | (ROOT_W'(1) << K);
				end else begin
					sq_rem_s[j+1]  <= sq_rem_s[j];
					sq_root_s[j+1] <= sq_root_s[j];
				end
			end
		end
	end

	// s4: overlap / outside test, push factor and divisor
	bctx_t              c4;
	logic [ROOT_W-1:0]  dlen;
	logic signed [DEN_W-1:0] dist_w;
	logic signed [DEN_W-1:0] lim_w;
	logic               hit;
	diff_t              factor;
	den_t               den;

	always_comb begin
		c4     = sq_ctx_s[ROOT_W];
		dlen   = sq_root_s[ROOT_W];
		dist_w = $signed({1'b0, dlen});
		lim_w  = DEN_W'(c4.it.lim);
		hit    = 1'b0;
		factor = '0;
		den    = '0;
		unique case (c4.it.kind)
			KIND_COLLIDE: begin
				hit    = (dlen != '0) && (dist_w < lim_w);
				factor = DIFF_W'(lim_w - dist_w);
				den    = {dlen, 1'b0};
			end
			KIND_ARENA: begin
				hit    = (dlen != '0) && (dist_w > lim_w);
				factor = c4.it.lim;
				den    = DEN_W'(dlen);
			end
			KIND_INTEGRATE, KIND_NONE: ;
		endcase
	end

	logic  v_s4;
	bctx_t c_s4;
	logic  hit_s4;
	diff_t factor_s4;
	den_t  den_s4;

	// s5: push numerators
	logic  v_s5;
	bctx_t c_s5;
	logic  hit_s5;
	den_t  den_s5;
	prod_t mx_s5;
	prod_t my_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s4 <= sq_v_s[ROOT_W];
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s4      <= c4;
			hit_s4    <= hit;
			factor_s4 <= factor;
			den_s4    <= den;
			c_s5      <= c_s4;
			hit_s5    <= hit_s4;
			den_s5    <= den_s4;
			mx_s5     <= PROD_W'(c_s4.it.dx) * PROD_W'(factor_s4);
			my_s5     <= PROD_W'(c_s4.it.dy) * PROD_W'(factor_s4);
		end
	end

	// rounding divider, one quotient bit per stage; index 0 is s6
	logic              dv_v_s   [QUO_W+1];
	dmeta_t            dv_m_s   [QUO_W+1];
	logic [DREM_W-1:0] dv_remx_s[QUO_W+1];
	logic [DREM_W-1:0] dv_remy_s[QUO_W+1];
	logic [QUO_W-1:0]  dv_qx_s  [QUO_W+1];
	logic [QUO_W-1:0]  dv_qy_s  [QUO_W+1];

	logic [PROD_W-1:0] magx;
	logic [PROD_W-1:0] magy;

	// magnitude plus half the divisor gives round half away from zero
	assign magx = mx_s5[PROD_W-1] ? PROD_W'(-mx_s5) : PROD_W'(mx_s5);
	assign magy = my_s5[PROD_W-1] ? PROD_W'(-my_s5) : PROD_W'(my_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v_s[0] <= 1'b0;
		else if (adv)
			dv_v_s[0] <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_m_s[0]    <= '{c: c_s5, hit: hit_s5, den: den_s5,
				negx: mx_s5[PROD_W-1], negy: my_s5[PROD_W-1]};
			dv_remx_s[0] <= DREM_W'(magx) + DREM_W'(den_s5 >> 1);
			dv_remy_s[0] <= DREM_W'(magy) + DREM_W'(den_s5 >> 1);
			dv_qx_s[0]   <= '0;
			dv_qy_s[0]   <= '0;
		end
	end

	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		localparam int K = QUO_W - 1 - j;
		logic [DREM_W-1:0] trial;

		assign trial = DREM_W'(dv_m_s[j].den) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[j+1] <= 1'b0;
			else if (adv)
				dv_v_s[j+1] <= dv_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_m_s[j+1] <= dv_m_s[j];
				if (dv_remx_s[j] >= trial) begin
					dv_remx_s[j+1] <= dv_remx_s[j] - trial;
					dv_qx_s[j+1]   <= dv_qx_s[j] | (QUO_W'(1) << K);
				end else begin
					dv_remx_s[j+1] <= dv_remx_s[j];
					dv_qx_s[j+1]   <= dv_qx_s[j];
				end
				if (dv_remy_s[j] >= trial) begin
					dv_remy_s[j+1] <= dv_remy_s[j] - trial;
					dv_qy_s[j+1]   <= dv_qy_s[j] | (QUO_W'(1) << K);
				end else begin
					dv_remy_s[j+1] <= dv_remy_s[j];
					dv_qy_s[j+1]   <= dv_qy_s[j];
				end
			end
		end
	end

	// s7: apply pushes, saturate, output register
	dmeta_t m7;
	logic signed [QUO_W:0] pushx;
	logic signed [QUO_W:0] pushy;
	wide_t cxw;
	wide_t cyw;
	pos_t  nx, ny, npx, npy, onx, ony;
	logic  mv;

	always_comb begin
		m7    = dv_m_s[QUO_W];
		pushx = m7.negx ? -$signed({1'b0, dv_qx_s[QUO_W]}) : $signed({1'b0, dv_qx_s[QUO_W]});
		pushy = m7.negy ? -$signed({1'b0, dv_qy_s[QUO_W]}) : $signed({1'b0, dv_qy_s[QUO_W]});
		cxw   = $signed(SAT_W'(cfg.center_x));
		cyw   = $signed(SAT_W'(cfg.center_y));
		nx    = m7.c.it.px;
		ny    = m7.c.it.py;
		npx   = m7.c.it.qx;
		npy   = m7.c.it.qy;
		onx   = '0;
		ony   = '0;
		mv    = 1'b0;
		unique case (m7.c.it.kind)
			KIND_INTEGRATE: begin
				nx  = m7.c.ix;
				ny  = m7.c.iy;
				npx = m7.c.it.px;
				npy = m7.c.it.py;
			end
			KIND_COLLIDE: begin
				onx = m7.c.it.ox;
				ony = m7.c.it.oy;
				if (m7.hit) begin
					nx  = sat_pos(SAT_W'(m7.c.it.px) + SAT_W'(pushx));
					ny  = sat_pos(SAT_W'(m7.c.it.py) + SAT_W'(pushy));
					onx = sat_pos(SAT_W'(m7.c.it.ox) - SAT_W'(pushx));
					ony = sat_pos(SAT_W'(m7.c.it.oy) - SAT_W'(pushy));
					mv  = 1'b1;
				end
			end
			KIND_ARENA: begin
				if (m7.hit) begin
					nx = sat_pos(cxw + SAT_W'(pushx));
					ny = sat_pos(cyw + SAT_W'(pushy));
					mv = 1'b1;
				end
			end
			KIND_NONE: ;
		endcase
	end

	logic v_s7;
	pos_t nx_s7, ny_s7, npx_s7, npy_s7, onx_s7, ony_s7;
	logic mv_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (adv)
			v_s7 <= dv_v_s[QUO_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s7  <= nx;
			ny_s7  <= ny;
			npx_s7 <= npx;
			npy_s7 <= npy;
			onx_s7 <= onx;
			ony_s7 <= ony;
			mv_s7  <= mv;
		end
	end

	assign rsp.valid       = v_s7;
	assign rsp.new_x       = nx_s7;
	assign rsp.new_y       = ny_s7;
	assign rsp.new_prev_x  = npx_s7;
	assign rsp.new_prev_y  = npy_s7;
	assign rsp.other_new_x = onx_s7;
	assign rsp.other_new_y = ony_s7;
	assign rsp.moved       = mv_s7;

endmodule

@@ src/verlet_circle_particle_solver_top.sv @@
// Verlet particle solver top: config registers, front, item queue, back.
// Depends on vcps_pkg, vcps_if, vcps_front, vcps_queue, vcps_back.
//
//  channel | dir | handshake   | carries
//  --------+-----+-------------+-----------------------------------------
//  req     | in  | valid/ready | kind, positions, radii, step_time
//  rsp     | out | valid/ready | new positions, new prev, other, moved
//  cfg     | in  | cfg_we      | register index and data, write only
//
// One item per cycle sustained while rsp is ready; an item passes the front
// register, the queue and the back pipeline to rsp.valid (the back is set
// by two 27-stage chains, square root and divider). Reset clears config to
// defaults and empties all stages. A stalled rsp freezes the back; the front
// keeps taking items until the 4-entry queue fills.
module verlet_circle_particle_solver_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vcps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vcps_pkg::CFG_DATA_W-1:0] cfg_data,
	vcps_req_if.sink                        req,
	vcps_rsp_if.source                      rsp
);
	import vcps_pkg::*;

	cfg_t  cfg_q;
	item_t f_item;
	logic  f_valid;
	logic  f_ready;
	item_t b_item;
	logic  b_valid;
	logic  b_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gravity_x <= '0;
			cfg_q.gravity_y <= GRAV_Y_RST;
			cfg_q.center_x  <= ARENA_RST;
			cfg_q.center_y  <= ARENA_RST;
			cfg_q.arena_r   <= ARENA_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRAVITY_X: cfg_q.gravity_x <= cfg_data[GRAV_W-1:0];
				CFG_GRAVITY_Y: cfg_q.gravity_y <= cfg_data[GRAV_W-1:0];
				CFG_CENTER_X:  cfg_q.center_x  <= cfg_data[ARENA_W-1:0];
				CFG_CENTER_Y:  cfg_q.center_y  <= cfg_data[ARENA_W-1:0];
				CFG_ARENA_R:   cfg_q.arena_r   <= cfg_data[ARENA_W-1:0];
				default: ;
			endcase
		end
	end

	vcps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.req        (req),
		.item       (f_item),
		.item_valid (f_valid),
		.item_ready (f_ready)
	);

	vcps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (f_item),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_item   (b_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready)
	);

	vcps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (b_item),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.rsp        (rsp)
	);

endmodule

@@ src/vcps_checker.sv @@
// vcps_checker: port-level checks of the particle solver, bound to the top.
// Depends on vcps_pkg and verlet_circle_particle_solver_top.
module vcps_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input vcps_pkg::pos_t rsp_new_x,
	input logic           rsp_moved
);
	// front + queue + back stages
	localparam logic [6:0] PEND_MAX = 7'd66;

	logic [6:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + 7'(req_valid && req_ready) - 7'(rsp_valid && rsp_ready);
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_new_x) && $stable(rsp_moved))
		else $error("rsp payload changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != '0)
		else $error("result without an outstanding item");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_MAX)
		else $error("more items outstanding than the pipeline holds");

endmodule

bind verlet_circle_particle_solver_top vcps_checker u_vcps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_new_x (rsp.new_x),
	.rsp_moved (rsp.moved)
);
